// ----- design/rational_arithmetic_unit_top_assert.svh -----
// Assertion macros shared by the RTL.
`ifndef RATIONAL_ARITHMETIC_UNIT_TOP_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define RAU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rau assertion failed");
`define RAU_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("rau forbidden condition");
`else
`define RAU_ASSERT(lbl, prop)
`define RAU_NEVER(lbl, cond)
`endif

`endif

// ----- design/rau_pkg.sv -----
package rau_pkg;

  localparam logic [2:0] MODE_ADD = 3'd0;
  localparam logic [2:0] MODE_SUB = 3'd1;
  localparam logic [2:0] MODE_MUL = 3'd2;
  localparam logic [2:0] MODE_DIV = 3'd3;
  localparam logic [2:0] MODE_CMP = 3'd4;

  localparam logic [1:0] STS_OK   = 2'd0;
  localparam logic [1:0] STS_DIVZ = 2'd1;
  localparam logic [1:0] STS_OVF  = 2'd2;

  localparam logic [1:0] ORD_EQ = 2'b00;
  localparam logic [1:0] ORD_GT = 2'b01;
  localparam logic [1:0] ORD_LT = 2'b11;

  // 64 shift-add or shift-subtract steps per pass
  localparam int unsigned CNT_W = 6;
  localparam logic [CNT_W-1:0] CNT_LAST = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SIGN,
    ST_NORM,
    ST_GCD,
    ST_DIV,
    ST_FIN
  } rau_state_e;

  typedef struct packed {
    logic load;
    logic mul_step;
    logic sign_en;
    logic norm_en;
    logic gcd_step;
    logic div_load;
    logic div_step;
    logic out_load;
  } rau_cmd_t;

  typedef struct packed {
    logic skip;
    logic gcd_eq;
  } rau_sts_t;

endpackage

// ----- design/rau_datapath.sv -----
module rau_datapath import rau_pkg::*; #(
  parameter int unsigned WORD_BITS = 64
) (
  input  logic        clk_i,
  input  rau_cmd_t    cmd_i,
  output rau_sts_t    sts_o,
  input  logic [2:0]  mode_i,
  input  logic [63:0] a_num_i,
  input  logic [62:0] a_den_i,
  input  logic [63:0] b_num_i,
  input  logic [62:0] b_den_i,
  output logic [63:0] res_num_o,
  output logic [62:0] res_den_o,
  output logic [1:0]  order_o,
  output logic [1:0]  status_o
);

  localparam logic [128:0] OneW   = 129'd1;
  localparam logic [128:0] LimHi  = (OneW << (WORD_BITS - 1)) - OneW;
  localparam logic [128:0] LimLo  = ~(OneW << (WORD_BITS - 1)) + OneW;
  localparam logic [63:0]  Lim64  = 64'd1 << (WORD_BITS - 1);

  function automatic logic fits(input logic [128:0] v);
    fits = ($signed(v) <= $signed(LimHi)) && ($signed(v) >= $signed(LimLo));
  endfunction

  logic [2:0]   mode_q;
  logic         sgn_an_q, sgn_bn_q;
  logic         early_q;
  logic [1:0]   early_st_q;
  logic [63:0]  mx_q [3];
  logic [127:0] acc_q [3];
  logic [128:0] n_q, d_q;
  logic         ovf_q, nzero_q, rneg_q;
  logic [1:0]   ord_q;
  logic [63:0]  nmag_q, dmag_q, u_q, v_q, g_q;
  logic [5:0]   k_q;
  logic [63:0]  rn_q, rd_q, qn_q, qd_q;
  logic [63:0]  res_num_q, res_num_d;
  logic [62:0]  res_den_q, res_den_d;
  logic [1:0]   res_ord_q, res_ord_d, res_st_q, res_st_d;

  // load-time operand prep
  logic [63:0] abs_an, abs_bn;
  assign abs_an = a_num_i[63] ? (~a_num_i + 64'd1) : a_num_i;
  assign abs_bn = b_num_i[63] ? (~b_num_i + 64'd1) : b_num_i;

  // sign stage
  logic         sg1;
  logic [128:0] s1, s2, s3, v2, sum;
  always_comb begin
    sg1 = (mode_q == MODE_MUL) ? (sgn_an_q ^ sgn_bn_q) : sgn_an_q;
    s1  = {1'b0, acc_q[0]};
    s2  = {1'b0, acc_q[1]};
    s3  = {1'b0, acc_q[2]};
    if (sg1) s1 = ~s1 + OneW;
    if (sgn_bn_q) s2 = ~s2 + OneW;
    v2  = (mode_q == MODE_SUB) ? (~s2 + OneW) : s2;
    sum = s1 + v2;
  end

  // normalise stage
  logic [128:0] nabs, dabs;
  assign nabs = n_q[128] ? (~n_q + OneW) : n_q;
  assign dabs = d_q[128] ? (~d_q + OneW) : d_q;

  // divide step
  logic [64:0] tn, td;
  assign tn = {rn_q, qn_q[63]};
  assign td = {rd_q, qd_q[63]};

  // final result
  logic        fin_ovf;
  logic [63:0] nm_neg;
  assign fin_ovf = (qd_q > (Lim64 - 64'd1)) ||
                   (qn_q > (rneg_q ? Lim64 : (Lim64 - 64'd1)));
  assign nm_neg  = ~qn_q + 64'd1;

  always_comb begin
    res_num_d = '0;
    res_den_d = 63'd1;
    res_ord_d = ORD_EQ;
    res_st_d  = STS_OK;
    if (early_q) begin
      res_st_d = early_st_q;
    end else if (mode_q == MODE_CMP) begin
      res_ord_d = ord_q;
    end else if (ovf_q) begin
      res_st_d = STS_OVF;
    end else if (!nzero_q) begin
      if (fin_ovf) begin
        res_st_d = STS_OVF;
      end else begin
        res_num_d = rneg_q ? nm_neg : qn_q;
        res_den_d = qd_q[62:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q   <= mode_i;
      sgn_an_q <= a_num_i[63];
      sgn_bn_q <= b_num_i[63];
      mx_q[0]  <= abs_an;
      mx_q[1]  <= {1'b0, a_den_i};
      mx_q[2]  <= {1'b0, a_den_i};
      acc_q[0] <= {64'd0, (mode_i == MODE_MUL) ? abs_bn : {1'b0, b_den_i}};
      acc_q[1] <= {64'd0, abs_bn};
      acc_q[2] <= {64'd0, 1'b0, b_den_i};
      if (a_den_i == '0 || b_den_i == '0) begin
        early_q    <= 1'b1;
        early_st_q <= STS_DIVZ;
      end else if (mode_i > MODE_CMP) begin
        early_q    <= 1'b1;
        early_st_q <= STS_OK;
      end else if (mode_i == MODE_DIV && b_num_i == '0) begin
        early_q    <= 1'b1;
        early_st_q <= STS_DIVZ;
      end else begin
        early_q    <= 1'b0;
        early_st_q <= STS_OK;
      end
    end

    if (cmd_i.mul_step) begin
      for (int i = 0; i < 3; i++) begin
        acc_q[i] <= {({1'b0, acc_q[i][127:64]} +
                      (acc_q[i][0] ? {1'b0, mx_q[i]} : 65'd0)), acc_q[i][63:1]};
      end
    end

    if (cmd_i.sign_en) begin
      if ($signed(s1) < $signed(s2))      ord_q <= ORD_LT;
      else if ($signed(s1) > $signed(s2)) ord_q <= ORD_GT;
      else                                ord_q <= ORD_EQ;
      case (mode_q) inside
        MODE_ADD, MODE_SUB: begin
          n_q   <= sum;
          d_q   <= s3;
          ovf_q <= !fits(s1) || !fits(v2);
        end
        MODE_MUL: begin
          n_q   <= s1;
          d_q   <= s3;
          ovf_q <= 1'b0;
        end
        default: begin
          n_q   <= s1;
          d_q   <= s2;
          ovf_q <= 1'b0;
        end
      endcase
    end

    if (cmd_i.norm_en) begin
      ovf_q   <= ovf_q || !fits(n_q) || !fits(d_q);
      nzero_q <= (n_q == '0);
      rneg_q  <= n_q[128] ^ d_q[128];
      nmag_q  <= nabs[63:0];
      dmag_q  <= dabs[63:0];
      u_q     <= nabs[63:0];
      v_q     <= dabs[63:0];
      k_q     <= '0;
    end

    // binary gcd, one step a cycle
    if (cmd_i.gcd_step) begin
      case ({u_q[0], v_q[0]})
        2'b00: begin
          u_q <= u_q >> 1;
          v_q <= v_q >> 1;
          k_q <= k_q + 6'd1;
        end
        2'b01:   u_q <= u_q >> 1;
        2'b10:   v_q <= v_q >> 1;
        default: begin
          if (u_q > v_q) u_q <= (u_q - v_q) >> 1;
          else           v_q <= (v_q - u_q) >> 1;
        end
      endcase
    end

    if (cmd_i.div_load) begin
      g_q  <= u_q << k_q;
      rn_q <= '0;
      rd_q <= '0;
      qn_q <= nmag_q;
      qd_q <= dmag_q;
    end

    // two restoring dividers sharing the divisor
    if (cmd_i.div_step) begin
      if (tn >= {1'b0, g_q}) begin
        rn_q <= 64'(tn - {1'b0, g_q});
        qn_q <= {qn_q[62:0], 1'b1};
      end else begin
        rn_q <= tn[63:0];
        qn_q <= {qn_q[62:0], 1'b0};
      end
      if (td >= {1'b0, g_q}) begin
        rd_q <= 64'(td - {1'b0, g_q});
        qd_q <= {qd_q[62:0], 1'b1};
      end else begin
        rd_q <= td[63:0];
        qd_q <= {qd_q[62:0], 1'b0};
      end
    end

    if (cmd_i.out_load) begin
      res_num_q <= res_num_d;
      res_den_q <= res_den_d;
      res_ord_q <= res_ord_d;
      res_st_q  <= res_st_d;
    end
  end

  assign sts_o.skip   = early_q || (mode_q == MODE_CMP) || ovf_q || nzero_q;
  assign sts_o.gcd_eq = (u_q == v_q);

  assign res_num_o = res_num_q;
  assign res_den_o = res_den_q;
  assign order_o   = res_ord_q;
  assign status_o  = res_st_q;

endmodule

// ----- design/rau_ctrl.sv -----
`include "rational_arithmetic_unit_top_assert.svh"
module rau_ctrl import rau_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  input  rau_sts_t sts_i,
  output rau_cmd_t cmd_o
);

  rau_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_MUL;
      ST_MUL:  if (cnt_q == CNT_LAST) state_d = ST_SIGN;
      ST_SIGN: state_d = ST_NORM;
      ST_NORM: state_d = ST_GCD;
      ST_GCD: begin
        if (sts_i.skip)        state_d = ST_FIN;
        else if (sts_i.gcd_eq) state_d = ST_DIV;
      end
      ST_DIV:  if (cnt_q == CNT_LAST) state_d = ST_FIN;
      ST_FIN:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: cmd_o.load     = in_valid_i;
      ST_MUL:  cmd_o.mul_step = 1'b1;
      ST_SIGN: cmd_o.sign_en  = 1'b1;
      ST_NORM: cmd_o.norm_en  = 1'b1;
      ST_GCD: begin
        cmd_o.gcd_step = !sts_i.skip && !sts_i.gcd_eq;
        cmd_o.div_load = !sts_i.skip && sts_i.gcd_eq;
      end
      ST_DIV:  cmd_o.div_step = 1'b1;
      ST_FIN:  cmd_o.out_load = out_free;
      default: cmd_o = '0;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_o.load || cmd_o.div_load)          cnt_d = '0;
    else if (cmd_o.mul_step || cmd_o.div_step) cnt_d = cnt_q + 1'b1;
    out_valid_d = out_valid_q;
    if (cmd_o.out_load)    out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  `RAU_ASSERT(a_accept_starts_mul, (in_valid_i && !in_stall_o) |=> (state_q == ST_MUL && cnt_q == '0))
  `RAU_ASSERT(a_fin_gives_result, (state_q == ST_FIN && out_free) |=> (out_valid_q && state_q == ST_IDLE))
  `RAU_ASSERT(a_div_ends, (state_q == ST_DIV && cnt_q == CNT_LAST) |=> (state_q == ST_FIN))
  `RAU_NEVER(a_no_overwrite, cmd_o.out_load && out_valid_q && out_stall_i)

endmodule

// ----- design/rational_arithmetic_unit_top.sv -----
// Channel | Signals                                          | Direction
// --------+--------------------------------------------------+----------
// input   | in_valid_i, in_stall_o, mode_i, a_num_i, a_den_i, | in
//         | b_num_i, b_den_i                                 |
// output  | out_valid_o, out_stall_i, res_num_o, res_den_o,  | out
//         | order_o, status_o                                |
//
// One transaction at a time. An early error, compare, zero or overflow result
// skips the binary gcd loop and the divide; a full one runs the 64-step shift-add
// multiply, the binary gcd loop (one step a cycle) and the 64-step divide.
// rst_ni clears the controller asynchronously; datapath registers have no reset.
// A finished result sits in the output register while the next transaction is
// taken; a stalled output only holds the controller in its final state.
module rational_arithmetic_unit_top import rau_pkg::*; #(
  parameter int unsigned WORD_BITS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  mode_i,
  input  logic [63:0] a_num_i,
  input  logic [62:0] a_den_i,
  input  logic [63:0] b_num_i,
  input  logic [62:0] b_den_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] res_num_o,
  output logic [62:0] res_den_o,
  output logic [1:0]  order_o,
  output logic [1:0]  status_o
);

  // command and status between sequencer and datapath
  rau_cmd_t cmd;
  rau_sts_t sts;

  rau_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // multiply, sign/range check, gcd, divide and result packing
  rau_datapath #(
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk_i     (clk_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .mode_i    (mode_i),
    .a_num_i   (a_num_i),
    .a_den_i   (a_den_i),
    .b_num_i   (b_num_i),
    .b_den_i   (b_den_i),
    .res_num_o (res_num_o),
    .res_den_o (res_den_o),
    .order_o   (order_o),
    .status_o  (status_o)
  );

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps

module tb import rau_pkg::*; ();

  typedef struct {
    logic [2:0]  mode;
    logic [63:0] an;
    logic [62:0] ad;
    logic [63:0] bn;
    logic [62:0] bd;
  } frac_pair_t;

  typedef struct {
    logic [63:0] num;
    logic [62:0] den;
    logic [1:0]  ord;
    logic [1:0]  sts;
  } frac_res_t;

  localparam logic signed [129:0] WORD_MIN = -(130'sd1 <<< 63);
  localparam logic signed [129:0] WORD_MAX = (130'sd1 <<< 63) - 130'sd1;
  localparam int unsigned CYCLE_LIMIT = 5_000_000;
  localparam int unsigned HOLD_CYCLES = 700;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  mode_i = '0;
  logic [63:0] a_num_i = '0;
  logic [62:0] a_den_i = 63'd1;
  logic [63:0] b_num_i = '0;
  logic [62:0] b_den_i = 63'd1;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [63:0] res_num_o;
  logic [62:0] res_den_o;
  logic [1:0]  order_o;
  logic [1:0]  status_o;

  frac_pair_t  pending_pairs[$];
  frac_res_t   awaited_results[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_req = 1'b0;
  int unsigned hold_cnt = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;

  rational_arithmetic_unit_top dut (.*);

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------
  // Predictor: exact arithmetic on 130-bit signed intermediates
  // ---------------------------------------------------------------------
  function automatic logic [63:0] euclid_gcd(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return (x == 0) ? 64'd1 : x;
  endfunction

  function automatic bit in_word(logic signed [129:0] v);
    return (v >= WORD_MIN) && (v <= WORD_MAX);
  endfunction

  function automatic frac_res_t reduced_fraction(frac_pair_t p);
    frac_res_t r;
    logic signed [129:0] an, ad, bn, bd, p1, p2, n, d, nmag, dmag;
    logic [63:0] g, nm, dm;
    bit ok, neg;
    r = '{num: '0, den: 63'd1, ord: ORD_EQ, sts: STS_OK};
    if (p.ad == 0 || p.bd == 0) begin
      r.sts = STS_DIVZ;
      return r;
    end
    if (p.mode > MODE_CMP) return r;
    an = {{66{p.an[63]}}, p.an};
    bn = {{66{p.bn[63]}}, p.bn};
    ad = {67'd0, p.ad};
    bd = {67'd0, p.bd};
    ok = 1'b1;
    // cross products, exact at full width
    case (p.mode)
      MODE_CMP: begin
        p1 = an * bd;
        p2 = bn * ad;
        r.ord = (p1 < p2) ? ORD_LT : (p1 > p2) ? ORD_GT : ORD_EQ;
        return r;
      end
      MODE_ADD, MODE_SUB: begin
        p1 = an * bd;
        p2 = bn * ad;
        if (p.mode == MODE_SUB) p2 = -p2;
        ok = in_word(p1) && in_word(p2);
        n = p1 + p2;
        d = ad * bd;
      end
      MODE_MUL: begin
        n = an * bn;
        d = ad * bd;
      end
      default: begin
        if (p.bn == 0) begin
          r.sts = STS_DIVZ;
          return r;
        end
        n = an * bd;
        d = ad * bn;
      end
    endcase
    ok = ok && in_word(n) && in_word(d);
    if (ok && n != 0) begin
      nmag = (n < 0) ? -n : n;
      dmag = (d < 0) ? -d : d;
      g = euclid_gcd(nmag[63:0], dmag[63:0]);
      nm = nmag[63:0] / g;
      dm = dmag[63:0] / g;
      neg = (n < 0) != (d < 0);
      if (dm > 64'h7FFF_FFFF_FFFF_FFFF || nm > (neg ? 64'h8000_0000_0000_0000
                                                    : 64'h7FFF_FFFF_FFFF_FFFF)) begin
        ok = 1'b0;
      end else begin
        r.num = neg ? -nm : nm;
        r.den = dm[62:0];
      end
    end
    if (!ok) begin
      r.sts = STS_OVF;
      r.num = '0;
      r.den = 63'd1;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Operand generators: mostly small values so results stay in range,
  // with a share of full-width and extreme values
  // ---------------------------------------------------------------------
  function automatic logic [63:0] rand_num();
    logic [63:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = 64'($signed($urandom_range(200)) - 100);
      4, 5: v = {{32{1'b0}}, 32'($urandom)} - 64'h8000_0000;
      6, 7: v = {32'($urandom), 32'($urandom)};
      8: v = 64'($urandom_range(40)) * 64'($urandom_range(1000)) * 64'd6;
      default: begin
        case ($urandom_range(4))
          0: v = 64'h8000_0000_0000_0000;
          1: v = 64'h7FFF_FFFF_FFFF_FFFF;
          2: v = '1;
          3: v = 64'd1;
          default: v = '0;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic logic [62:0] rand_den();
    logic [62:0] v;
    case ($urandom_range(99))
      0: v = '0;
      1, 2: v = 63'h7FFF_FFFF_FFFF_FFFF;
      3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14: v = 63'({$urandom, $urandom});
      15, 16, 17, 18, 19, 20, 21, 22, 23, 24: v = 63'($urandom);
      default: v = 63'($urandom_range(1, 200));
    endcase
    return v;
  endfunction

  task automatic queue_pair(logic [2:0] m, logic [63:0] an, logic [62:0] ad,
                            logic [63:0] bn, logic [62:0] bd);
    frac_pair_t p;
    p = '{mode: m, an: an, ad: ad, bn: bn, bd: bd};
    pending_pairs.push_back(p);
  endtask

  task automatic queue_random(int unsigned count);
    logic [2:0] m;
    repeat (count) begin
      m = ($urandom_range(99) < 4) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(4));
      queue_pair(m, rand_num(), rand_den(), rand_num(), rand_den());
    end
  endtask

  task automatic wait_drained();
    while (pending_pairs.size() != 0 || in_valid_i || awaited_results.size() != 0)
      @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------
  // Driver: one transaction offered at a time, held while stalled
  // ---------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    frac_pair_t p;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o)
        awaited_results.push_back(reduced_fraction('{mode: mode_i, an: a_num_i,
                                                     ad: a_den_i, bn: b_num_i,
                                                     bd: b_den_i}));
      if (!in_valid_i || !in_stall_o) begin
        if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          p = pending_pairs.pop_front();
          mode_i     <= p.mode;
          a_num_i    <= p.an;
          a_den_i    <= p.ad;
          b_num_i    <= p.bn;
          b_den_i    <= p.bd;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted in cycles
  always @(posedge clk_i) begin
    if (rst_ni && hold_req && hold_cnt < HOLD_CYCLES)
      hold_cnt <= hold_cnt + 1;
  end

  // ---------------------------------------------------------------------
  // Monitor: compares each result with the oldest prediction and drives
  // the output stall, including one long hold-off when requested
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    frac_res_t e;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result num=%0d den=%0d", $time,
                   $signed(res_num_o), res_den_o);
        end else begin
          e = awaited_results.pop_front();
          if (res_num_o !== e.num) begin
            errors++;
            $display("%0t: res_num exp %0d got %0d", $time, $signed(e.num),
                     $signed(res_num_o));
          end
          if (res_den_o !== e.den) begin
            errors++;
            $display("%0t: res_den exp %0d got %0d", $time, e.den, res_den_o);
          end
          if (order_o !== e.ord) begin
            errors++;
            $display("%0t: order exp %b got %b", $time, e.ord, order_o);
          end
          if (status_o !== e.sts) begin
            errors++;
            $display("%0t: status exp %0d got %0d", $time, e.sts, status_o);
          end
        end
      end
      if (hold_req && hold_cnt < HOLD_CYCLES) begin
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus sequence
  // ---------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // directed: every mode, sign and range extremes, error paths
    queue_pair(MODE_ADD, 64'd1, 63'd2, 64'd1, 63'd3);
    queue_pair(MODE_SUB, 64'd1, 63'd2, 64'd1, 63'd2);          // reduces to zero
    queue_pair(MODE_SUB, -64'sd3, 63'd4, 64'd5, 63'd6);
    queue_pair(MODE_MUL, 64'd6, 63'd4, -64'sd2, 63'd9);
    queue_pair(MODE_DIV, 64'd3, 63'd7, -64'sd9, 63'd14);
    queue_pair(MODE_DIV, 64'd3, 63'd7, 64'd0, 63'd5);          // divide by zero fraction
    queue_pair(MODE_CMP, 64'd1, 63'd3, 64'd1, 63'd2);
    queue_pair(MODE_CMP, 64'd2, 63'd4, 64'd1, 63'd2);
    queue_pair(MODE_CMP, -64'sd1, 63'd3, -64'sd1, 63'd2);
    queue_pair(MODE_CMP, 64'h8000_0000_0000_0000, 63'h7FFF_FFFF_FFFF_FFFF,
               64'h7FFF_FFFF_FFFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF);
    queue_pair(MODE_ADD, 64'd1, 63'd0, 64'd1, 63'd1);          // zero denominators
    queue_pair(MODE_CMP, 64'd1, 63'd1, 64'd1, 63'd0);
    queue_pair(3'd5, 64'd1, 63'd1, 64'd1, 63'd1);              // unused modes
    queue_pair(3'd6, '1, 63'd3, 64'd7, 63'd9);
    queue_pair(3'd7, 64'h8000_0000_0000_0000, 63'h7FFF_FFFF_FFFF_FFFF, '1, 63'd1);
    queue_pair(MODE_MUL, 64'h7FFF_FFFF_FFFF_FFFF, 63'd1, 64'h7FFF_FFFF_FFFF_FFFF, 63'd1);
    queue_pair(MODE_MUL, 64'h8000_0000_0000_0000, 63'd1, 64'd1, 63'd1);
    queue_pair(MODE_DIV, 64'h8000_0000_0000_0000, 63'd1, '1, 63'd1);   // negation overflow
    queue_pair(MODE_SUB, 64'd0, 63'd1, 64'h8000_0000_0000_0000, 63'd1);
    queue_pair(MODE_ADD, 64'h7FFF_FFFF_FFFF_FFFF, 63'd1, 64'd1, 63'd1);
    queue_pair(MODE_ADD, 64'd1, 63'h7FFF_FFFF_FFFF_FFFF, 64'd1, 63'd2);
    queue_pair(MODE_DIV, 64'd5, 63'h7FFF_FFFF_FFFF_FFFF, 64'd5, 63'h7FFF_FFFF_FFFF_FFFF);
    queue_pair(MODE_MUL, 64'd0, 63'd5, -64'sd7, 63'd3);
    wait_drained();

    // no idling
    queue_random(480);
    wait_drained();

    // sender idle, plus one long receiver hold-off that backs up the input
    send_idle_pct = 56;
    queue_random(480);
    @(negedge clk_i) hold_req = 1'b1;
    wait_drained();

    // receiver stalling
    send_idle_pct  = 0;
    recv_stall_pct = 56;
    queue_random(480);
    wait_drained();

    // both
    send_idle_pct  = 21;
    recv_stall_pct = 21;
    queue_random(480);
    wait_drained();

    repeat (400) @(posedge clk_i);
    if (errors == 0 && awaited_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
